[hdl/tcdc_pkg.sv]
// ----------------------------------------------------------------------------
// tcdc_pkg: shared definitions for the two-channel dimmer controller
// Field widths, request and register codes, reset defaults and helpers.
// ----------------------------------------------------------------------------
package tcdc_pkg;

  localparam int LEVEL_W    = 6;   // brightness index
  localparam int COLOR_W    = 5;   // color index
  localparam int DELAY_W    = 15;  // idle tick counter
  localparam int STORED_W   = 8;   // stored brightness and color
  localparam int PEND_W     = 8;   // pending encoder movement, signed
  localparam int DELTA_W    = 5;   // encoder delta, signed
  localparam int TIDX_W     = 6;   // table index field
  localparam int TVAL_W     = 16;  // table value field
  localparam int WEIGHT_W   = 9;   // color weight, 0..256
  localparam int DUTY_W     = 16;
  localparam int FRAC_SHIFT = 8;
  localparam int PROD_W     = TVAL_W + WEIGHT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam int DEF_BRIGHT_LEVELS = 64;
  localparam int DEF_COLOR_LEVELS  = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
  localparam logic signed [PEND_W-1:0] PEND_MAX = 8'sd127;
  localparam logic signed [PEND_W-1:0] PEND_MIN = -8'sd127;

  localparam logic [LEVEL_W-1:0]  RST_LEVEL_MIN     = 6'd1;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL_MAX     = 6'd63;
  localparam logic [COLOR_W-1:0]  RST_COLOR_MIN     = 5'd0;
  localparam logic [COLOR_W-1:0]  RST_COLOR_MAX     = 5'd31;
  localparam logic [COLOR_W-1:0]  RST_COLOR_NEUTRAL = 5'd16;
  localparam logic [DELAY_W-1:0]  RST_OFF_DELAY     = 15'd1000;
  localparam logic [STORED_W-1:0] RST_STORED_BRIGHT = 8'd1;
  localparam logic [STORED_W-1:0] RST_STORED_COLOR  = 8'd16;

  typedef enum logic [1:0] {
    REQ_TICK        = 2'd0,
    REQ_LOAD_BRIGHT = 2'd1,
    REQ_LOAD_COLOR  = 2'd2,
    REQ_START       = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_MIN     = 3'd0,
    CFG_LEVEL_MAX     = 3'd1,
    CFG_COLOR_MIN     = 3'd2,
    CFG_COLOR_MAX     = 3'd3,
    CFG_COLOR_NEUTRAL = 3'd4,
    CFG_OFF_DELAY     = 3'd5,
    CFG_STORED_BRIGHT = 3'd6,
    CFG_STORED_COLOR  = 3'd7
  } cfg_idx_t;

  // Status flags that travel with an item down the pipeline.
  typedef struct packed {
    logic               output_on;
    logic               power_off;
    logic [LEVEL_W-1:0] save_brightness;
    logic [COLOR_W-1:0] save_color;
  } status_t;

  // Clamp a widened sum of pending movement and a new delta to -127..127.
  function automatic logic signed [PEND_W-1:0] sat127(input logic signed [PEND_W:0] v);
    logic signed [PEND_W-1:0] r;
    if (v > 9'sd127) begin
      r = PEND_MAX;
    end else if (v < -9'sd127) begin
      r = PEND_MIN;
    end else begin
      r = v[PEND_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/two_channel_dimmer_control_top.sv]
// An accepted item's table reads are registered in stage 1, and its duties
// then go into the output register after the multiply; out_ready can stall both.
// Throughput: one item per cycle while out_ready holds high; the controller
// state is updated in the accept cycle and both table reads use that state.
// Reset clears the controller state and the configuration registers to their
// defaults; the two lookup tables are not cleared and must be loaded.
// ----------------------------------------------------------------------------
// two_channel_dimmer_control_top: warm/cool LED dimmer controller
// Encoder-driven brightness and color stepping, power and neutral buttons,
// idle power-off, and table-based warm and cool duty generation.
// ----------------------------------------------------------------------------
module two_channel_dimmer_control_top #(
  parameter int BRIGHT_LEVELS = tcdc_pkg::DEF_BRIGHT_LEVELS,
  parameter int COLOR_LEVELS  = tcdc_pkg::DEF_COLOR_LEVELS
) (
  input  logic                                clk,
  input  logic                                rst,

  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [tcdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcdc_pkg::CFG_DATA_W-1:0]     cfg_data,

  // Input item channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic signed [tcdc_pkg::DELTA_W-1:0] bright_delta,
  input  logic signed [tcdc_pkg::DELTA_W-1:0] color_delta,
  input  logic                                power_press,
  input  logic                                neutral_press,
  input  logic [tcdc_pkg::TIDX_W-1:0]         table_index,
  input  logic [tcdc_pkg::TVAL_W-1:0]         table_value,

  // Result item channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tcdc_pkg::DUTY_W-1:0]         warm_duty,
  output logic [tcdc_pkg::DUTY_W-1:0]         cool_duty,
  output logic                                output_on,
  output logic                                power_off,
  output logic [tcdc_pkg::LEVEL_W-1:0]        save_brightness,
  output logic [tcdc_pkg::COLOR_W-1:0]        save_color
);

  // Table address widths. The index fields are widened first so that a table
  // larger than the index range still gets a well-formed address.
  localparam int BA_W = $clog2(BRIGHT_LEVELS);
  localparam int CA_W = $clog2(COLOR_LEVELS);
  localparam int BX_W = (BA_W > tcdc_pkg::TIDX_W) ? BA_W : tcdc_pkg::TIDX_W;
  localparam int CX_W = (CA_W > tcdc_pkg::TIDX_W) ? CA_W : tcdc_pkg::TIDX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [tcdc_pkg::LEVEL_W-1:0]  level_min;
  logic [tcdc_pkg::LEVEL_W-1:0]  level_max;
  logic [tcdc_pkg::COLOR_W-1:0]  color_min;
  logic [tcdc_pkg::COLOR_W-1:0]  color_max;
  logic [tcdc_pkg::COLOR_W-1:0]  color_neutral;
  logic [tcdc_pkg::DELAY_W-1:0]  off_delay;
  logic [tcdc_pkg::STORED_W-1:0] stored_bright;
  logic [tcdc_pkg::STORED_W-1:0] stored_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_min     <= tcdc_pkg::RST_LEVEL_MIN;
      level_max     <= tcdc_pkg::RST_LEVEL_MAX;
      color_min     <= tcdc_pkg::RST_COLOR_MIN;
      color_max     <= tcdc_pkg::RST_COLOR_MAX;
      color_neutral <= tcdc_pkg::RST_COLOR_NEUTRAL;
      off_delay     <= tcdc_pkg::RST_OFF_DELAY;
      stored_bright <= tcdc_pkg::RST_STORED_BRIGHT;
      stored_color  <= tcdc_pkg::RST_STORED_COLOR;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcdc_pkg::CFG_LEVEL_MIN:     level_min     <= cfg_data[tcdc_pkg::LEVEL_W-1:0];
        tcdc_pkg::CFG_LEVEL_MAX:     level_max     <= cfg_data[tcdc_pkg::LEVEL_W-1:0];
        tcdc_pkg::CFG_COLOR_MIN:     color_min     <= cfg_data[tcdc_pkg::COLOR_W-1:0];
        tcdc_pkg::CFG_COLOR_MAX:     color_max     <= cfg_data[tcdc_pkg::COLOR_W-1:0];
        tcdc_pkg::CFG_COLOR_NEUTRAL: color_neutral <= cfg_data[tcdc_pkg::COLOR_W-1:0];
        tcdc_pkg::CFG_OFF_DELAY:     off_delay     <= cfg_data[tcdc_pkg::DELAY_W-1:0];
        tcdc_pkg::CFG_STORED_BRIGHT: stored_bright <= cfg_data[tcdc_pkg::STORED_W-1:0];
        tcdc_pkg::CFG_STORED_COLOR:  stored_color  <= cfg_data[tcdc_pkg::STORED_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  // Stage 1 holds the registered table reads, the output register holds the
  // finished duties. Each stage moves whenever the one after it has room, so
  // a new item is taken while a finished result still waits.
  logic s1_valid;
  logic in_accept;
  logic s1_move;

  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Controller state and its update in the accept cycle
  // --------------------------------------------------------------------------
  logic [tcdc_pkg::LEVEL_W-1:0]        bright_index, bright_index_next;
  logic [tcdc_pkg::COLOR_W-1:0]        color_index, color_index_next;
  logic [tcdc_pkg::LEVEL_W-1:0]        saved_bright, saved_bright_next;
  logic [tcdc_pkg::DELAY_W-1:0]        idle_ticks, idle_ticks_next;
  logic signed [tcdc_pkg::PEND_W-1:0]  pending_bright, pending_bright_next;
  logic signed [tcdc_pkg::PEND_W-1:0]  pending_color, pending_color_next;
  logic                                pending_neutral, pending_neutral_next;
  logic                                halted, halted_next;

  logic signed [tcdc_pkg::PEND_W:0]    db_sum, dc_sum;
  logic signed [tcdc_pkg::PEND_W-1:0]  db, dc;
  logic                                neu;
  logic [tcdc_pkg::LEVEL_W-1:0]        b_step;
  logic [tcdc_pkg::COLOR_W-1:0]        c_step;
  logic [tcdc_pkg::LEVEL_W-1:0]        b_tick;
  logic [tcdc_pkg::DELAY_W-1:0]        idle_inc;

  assign db_sum = {pending_bright[tcdc_pkg::PEND_W-1], pending_bright}
                + {{(tcdc_pkg::PEND_W + 1 - tcdc_pkg::DELTA_W){bright_delta[tcdc_pkg::DELTA_W-1]}},
                   bright_delta};
  assign dc_sum = {pending_color[tcdc_pkg::PEND_W-1], pending_color}
                + {{(tcdc_pkg::PEND_W + 1 - tcdc_pkg::DELTA_W){color_delta[tcdc_pkg::DELTA_W-1]}},
                   color_delta};
  assign db  = tcdc_pkg::sat127(db_sum);
  assign dc  = tcdc_pkg::sat127(dc_sum);
  assign neu = pending_neutral | neutral_press;

  // One step of brightness and color in the direction of the movement.
  always_comb begin
    b_step = bright_index;
    if (db > 0 && bright_index < level_max) begin
      b_step = bright_index + 6'd1;
    end
    if (db < 0 && b_step > level_min) begin
      b_step = b_step - 6'd1;
    end
    c_step = color_index;
    if (dc > 0 && color_index < color_max) begin
      c_step = color_index + 5'd1;
    end
    if (dc < 0 && c_step > color_min) begin
      c_step = c_step - 5'd1;
    end
  end

  always_comb begin
    bright_index_next    = bright_index;
    color_index_next     = color_index;
    saved_bright_next    = saved_bright;
    idle_ticks_next      = idle_ticks;
    pending_bright_next  = pending_bright;
    pending_color_next   = pending_color;
    pending_neutral_next = pending_neutral;
    halted_next          = halted;
    b_tick               = bright_index;
    idle_inc             = idle_ticks + 15'd1;

    unique case (req_type)
      tcdc_pkg::REQ_START: begin
        if (stored_bright < {2'b00, level_min} || stored_bright > {2'b00, level_max}) begin
          bright_index_next = level_min;
        end else begin
          bright_index_next = stored_bright[tcdc_pkg::LEVEL_W-1:0];
        end
        if (stored_color < {3'b000, color_min} || stored_color > {3'b000, color_max}) begin
          color_index_next = color_neutral;
        end else begin
          color_index_next = stored_color[tcdc_pkg::COLOR_W-1:0];
        end
        saved_bright_next    = bright_index_next;
        idle_ticks_next      = '0;
        pending_bright_next  = '0;
        pending_color_next   = '0;
        pending_neutral_next = 1'b0;
        halted_next          = 1'b0;
      end
      tcdc_pkg::REQ_TICK: begin
        if (!halted) begin
          if (bright_index >= level_min) begin
            // Output on: step, then apply the buttons, then drop pending.
            b_tick           = b_step;
            color_index_next = c_step;
            if (power_press) begin
              saved_bright_next = b_step;
              b_tick            = '0;
            end
            if (neu) begin
              color_index_next = color_neutral;
            end
            pending_bright_next  = '0;
            pending_color_next   = '0;
            pending_neutral_next = 1'b0;
          end else begin
            // Output off: movement waits until the output comes back on.
            if (power_press) begin
              b_tick = saved_bright;
            end
            pending_bright_next  = db;
            pending_color_next   = dc;
            pending_neutral_next = neu;
          end
          bright_index_next = b_tick;
          if (b_tick == '0) begin
            idle_ticks_next = idle_inc;
            if (idle_inc == off_delay) begin
              halted_next = 1'b1;
            end
          end else begin
            idle_ticks_next = '0;
          end
        end
      end
      default: ;  // table loads leave the controller state alone
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_index    <= '0;
      color_index     <= '0;
      saved_bright    <= '0;
      idle_ticks      <= '0;
      pending_bright  <= '0;
      pending_color   <= '0;
      pending_neutral <= 1'b0;
      halted          <= 1'b0;
    end else if (in_accept) begin
      bright_index    <= bright_index_next;
      color_index     <= color_index_next;
      saved_bright    <= saved_bright_next;
      idle_ticks      <= idle_ticks_next;
      pending_bright  <= pending_bright_next;
      pending_color   <= pending_color_next;
      pending_neutral <= pending_neutral_next;
      halted          <= halted_next;
    end
  end

  // --------------------------------------------------------------------------
  // Lookup tables: one write and one registered read each per cycle
  // --------------------------------------------------------------------------
  logic [tcdc_pkg::TVAL_W-1:0]   bright_mem [BRIGHT_LEVELS];
  logic [tcdc_pkg::WEIGHT_W-1:0] color_mem  [COLOR_LEVELS];

  logic [BX_W-1:0] b_wr_ext, b_rd_ext;
  logic [CX_W-1:0] c_wr_ext, c_rd_ext;
  logic [BA_W-1:0] b_wr_addr, b_rd_addr;
  logic [CA_W-1:0] c_wr_addr, c_rd_addr;
  logic            b_wr_en, c_wr_en;
  logic            b_rd_ok, c_rd_ok;
  logic [tcdc_pkg::WEIGHT_W-1:0] c_wr_data;

  assign b_wr_ext  = BX_W'(table_index);
  assign c_wr_ext  = CX_W'(table_index);
  assign b_rd_ext  = BX_W'(bright_index_next);
  assign c_rd_ext  = CX_W'(color_index_next);
  assign b_wr_addr = b_wr_ext[BA_W-1:0];
  assign c_wr_addr = c_wr_ext[CA_W-1:0];
  assign b_rd_addr = b_rd_ext[BA_W-1:0];
  assign c_rd_addr = c_rd_ext[CA_W-1:0];

  assign b_wr_en = in_accept && (req_type == tcdc_pkg::REQ_LOAD_BRIGHT)
                && (32'(table_index) < BRIGHT_LEVELS);
  assign c_wr_en = in_accept && (req_type == tcdc_pkg::REQ_LOAD_COLOR)
                && (32'(table_index) < COLOR_LEVELS);
  assign b_rd_ok = 32'(bright_index_next) < BRIGHT_LEVELS;
  assign c_rd_ok = 32'(color_index_next) < COLOR_LEVELS;

  // Color weights saturate at full scale.
  assign c_wr_data = (table_value > 16'(tcdc_pkg::WEIGHT_FULL))
                   ? tcdc_pkg::WEIGHT_FULL : table_value[tcdc_pkg::WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (b_wr_en) begin
      bright_mem[b_wr_addr] <= table_value;
    end
    if (c_wr_en) begin
      color_mem[c_wr_addr] <= c_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: registered reads. A load that writes the very entry its own
  // result reads is forwarded, since the array returns the old word then.
  // --------------------------------------------------------------------------
  logic [tcdc_pkg::TVAL_W-1:0]   s1_b_mem;
  logic [tcdc_pkg::WEIGHT_W-1:0] s1_c_mem;
  logic                          s1_b_fwd, s1_c_fwd;
  logic                          s1_b_ok, s1_c_ok;
  logic [tcdc_pkg::TVAL_W-1:0]   s1_fwd_val;
  logic [tcdc_pkg::WEIGHT_W-1:0] s1_c_fwd_val;
  tcdc_pkg::status_t             s1_status;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_b_mem     <= bright_mem[b_rd_addr];
      s1_c_mem     <= color_mem[c_rd_addr];
      s1_b_fwd     <= b_wr_en && (table_index == bright_index_next);
      s1_c_fwd     <= c_wr_en && (table_index == {1'b0, color_index_next});
      s1_b_ok      <= b_rd_ok;
      s1_c_ok      <= c_rd_ok;
      s1_fwd_val   <= table_value;
      s1_c_fwd_val <= c_wr_data;
      s1_status.output_on       <= bright_index_next >= level_min;
      s1_status.power_off       <= halted_next;
      s1_status.save_brightness <= saved_bright_next;
      s1_status.save_color      <= color_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: duty multiply into the output register
  // --------------------------------------------------------------------------
  logic [tcdc_pkg::TVAL_W-1:0]   bval;
  logic [tcdc_pkg::WEIGHT_W-1:0] w, w_inv;
  logic [tcdc_pkg::PROD_W-1:0]   prod_warm, prod_cool;

  always_comb begin
    if (!s1_b_ok) begin
      bval = '0;
    end else if (s1_b_fwd) begin
      bval = s1_fwd_val;
    end else begin
      bval = s1_b_mem;
    end
    if (!s1_c_ok) begin
      w = '0;
    end else if (s1_c_fwd) begin
      w = s1_c_fwd_val;
    end else begin
      w = s1_c_mem;
    end
  end

  assign w_inv     = tcdc_pkg::WEIGHT_FULL - w;
  assign prod_warm = tcdc_pkg::PROD_W'(bval) * tcdc_pkg::PROD_W'(w);
  assign prod_cool = tcdc_pkg::PROD_W'(bval) * tcdc_pkg::PROD_W'(w_inv);

  always_ff @(posedge clk) begin
    if (s1_move) begin
      warm_duty       <= prod_warm[tcdc_pkg::FRAC_SHIFT +: tcdc_pkg::DUTY_W];
      cool_duty       <= prod_cool[tcdc_pkg::FRAC_SHIFT +: tcdc_pkg::DUTY_W];
      output_on       <= s1_status.output_on;
      power_off       <= s1_status.power_off;
      save_brightness <= s1_status.save_brightness;
      save_color      <= s1_status.save_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The block only halts with the output fully off, and nothing but a start
  // brings it back.
  a_halt_dark: assert property (@(posedge clk) disable iff (rst)
    halted |-> (bright_index == '0))
    else $error("halted with nonzero brightness");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (halted && !(in_accept && req_type == tcdc_pkg::REQ_START)) |=> halted)
    else $error("halt cleared without a start item");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (in_accept && req_type == tcdc_pkg::REQ_START) |=> !halted)
    else $error("start item left the block halted");

  // Pending movement is clamped symmetrically, so the most negative code
  // never appears.
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    (pending_bright != 8'sh80) && (pending_color != 8'sh80))
    else $error("pending movement out of range");

  // With the output register empty the pipeline must take new items.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule
